FILE: rtl/timed_window_vector_sum_assert.svh
// Assertion macros shared by the timed window vector sum RTL.
`ifndef TIMED_WINDOW_VECTOR_SUM_ASSERT_SVH
`define TIMED_WINDOW_VECTOR_SUM_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TWS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tws_pkg.sv
// Package with types, codes and defaults of the timed window vector sum.
package tws_pkg;

  localparam int LISTENERS_DEF  = 4;
  localparam int FIFO_DEPTH_DEF = 16;
  localparam int FEATURES_DEF   = 4;
  localparam int IN_FEATS       = 4;

  localparam logic [31:0] WINDOW_RST = 32'd1000;
  localparam logic [2:0]  FEATS_RST  = 3'd4;
  localparam logic [4:0]  DEPTH_RST  = 5'd16;

  typedef enum logic [1:0] {
    ACT_PUSH   = 2'd0,
    ACT_EXPIRE = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_WINDOW = 2'd0,
    REG_FEATS  = 2'd1,
    REG_DEPTH  = 2'd2,
    REG_SPARE  = 2'd3
  } reg_idx_t;

  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_SUM    = 1'b1;

  // Per-lane control from the sequencer.
  typedef struct packed {
    logic we;
    logic add;
    logic sub;
  } lane_ctl_t;

endpackage

FILE: rtl/tws_if.sv
// Valid/ready channel interfaces for the input items and the result beats.
interface tws_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [1:0]  listener;
  logic [31:0] time_ms;
  logic [31:0] feature_0;
  logic [31:0] feature_1;
  logic [31:0] feature_2;
  logic [31:0] feature_3;

  modport source (output valid, action, listener, time_ms, feature_0, feature_1,
                  feature_2, feature_3, input ready);
  modport sink (input valid, action, listener, time_ms, feature_0, feature_1,
                feature_2, feature_3, output ready);
endinterface

interface tws_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [1:0]  listener_out;
  logic [31:0] stamp_out;
  logic [63:0] value_0;
  logic [63:0] value_1;
  logic [63:0] value_2;
  logic [63:0] value_3;
  logic        last;

  modport source (output valid, kind, listener_out, stamp_out, value_0, value_1,
                  value_2, value_3, last, input ready);
  modport sink (input valid, kind, listener_out, stamp_out, value_0, value_1,
                value_2, value_3, last, output ready);
endinterface

FILE: rtl/tws_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/tws_lane.sv
// One feature lane: record value store and the per-listener running sums.
module tws_lane
  import tws_pkg::*;
#(
  parameter int LISTENERS  = LISTENERS_DEF,
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
  localparam int LW = (LISTENERS > 1) ? $clog2(LISTENERS) : 1,
  localparam int SW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1,
  localparam int AW = LW + SW
) (
  input  logic          clk,
  input  logic          rst_n,
  input  lane_ctl_t     ctl,
  input  logic [LW-1:0] sel,
  input  logic [AW-1:0] waddr,
  input  logic [AW-1:0] raddr,
  input  logic [31:0]   wdata,
  output logic [31:0]   rdata,
  output logic [63:0]   sum
);

  logic [63:0] sums_r [LISTENERS];

  tws_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_vals (
    .clk   (clk),
    .we    (ctl.we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Running sums wrap at 64 bits; an eviction subtracts the head value read out.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LISTENERS; i++) begin
        sums_r[i] <= '0;
      end
    end else if (ctl.sub) begin
      sums_r[sel] <= sums_r[sel] - 64'(rdata);
    end else if (ctl.add) begin
      sums_r[sel] <= sums_r[sel] + 64'(wdata);
    end
  end

  assign sum = sums_r[sel];

endmodule

FILE: rtl/timed_window_vector_sum.sv
// Top level of the timed window vector sum: sequencer, record stores and lane merge.
//
// Input items arrive as beats on in_bus; results leave as beats on out_bus, and
// the last result of an item carries last. Configuration is written through
// cfg_we / cfg_index / cfg_data; the user must write it only while the block is
// idle, which the block itself does not enforce. A push goes from S_PUSH_RD to
// S_PUSH_WR, via S_PUSH_EV when the listener's FIFO is full; that state forces
// out the oldest record and waits out output stalls. An expire visits every
// listener and a query one: an empty FIFO needs S_EXP_CHK alone, and each head
// record checked needs S_EXP_CHK and S_EXP_EV, as the head is read from the
// record store and then compared with the window; each eviction loops back to
// read the next head. An expire ends in S_FLUSH, sending the held-back record, if
// any; a query ends in S_QRY with the sum reply, after any held-back record. One
// item is worked on at a time; in_bus.ready is high only while the sequencer is
// idle. Evicted records of an expire are held one beat back so that last can be
// set on the final one. When the receiver stalls, the output register holds
// its beat and the sequencer waits at its next beat.
// Reset clears all FIFO heads, counts and sums and loads the default
// configuration; no clearing pass is needed.
module timed_window_vector_sum
  import tws_pkg::*;
#(
  parameter int LISTENERS  = LISTENERS_DEF,
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
  parameter int FEATURES   = FEATURES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  tws_in_if.sink      in_bus,
  tws_out_if.source   out_bus,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

`include "timed_window_vector_sum_assert.svh"

  localparam int LW = (LISTENERS > 1) ? $clog2(LISTENERS) : 1;
  localparam int SW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int AW = LW + SW;
  localparam int TW = ((SW > CW) ? SW : CW) + 1;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b00000001,
    S_PUSH_RD = 8'b00000010,
    S_PUSH_EV = 8'b00000100,
    S_PUSH_WR = 8'b00001000,
    S_EXP_CHK = 8'b00010000,
    S_EXP_EV  = 8'b00100000,
    S_FLUSH   = 8'b01000000,
    S_QRY     = 8'b10000000
  } state_t;

  typedef enum logic [1:0] {
    SRC_REC  = 2'd0,
    SRC_PEND = 2'd1,
    SRC_SUM  = 2'd2,
    SRC_NONE = 2'd3
  } src_t;

  // Configuration registers.
  logic [31:0] window_r;
  logic [2:0]  feats_r;
  logic [4:0]  depth_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RST;
      feats_r  <= FEATS_RST;
      depth_r  <= DEPTH_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_WINDOW: window_r <= cfg_data;
        REG_FEATS:  feats_r  <= cfg_data[2:0];
        REG_DEPTH:  depth_r  <= cfg_data[4:0];
        default:    ;
      endcase
    end
  end

  // Sequencer and item registers.
  state_t        state_r, state_nxt;
  logic [1:0]    act_r;
  logic [LW-1:0] cur_l_r, cur_l_nxt;
  logic [31:0]   now_r;
  logic [31:0]   feat_r [IN_FEATS];

  logic [SW-1:0] heads_r  [LISTENERS];
  logic [CW-1:0] counts_r [LISTENERS];

  logic          pend_v_r;
  logic [LW-1:0] pend_l_r;
  logic [31:0]   pend_stamp_r;
  logic [31:0]   pend_val_r [IN_FEATS];

  logic          out_v_r;
  logic          out_kind_r;
  logic [1:0]    out_l_r;
  logic [31:0]   out_stamp_r;
  logic [63:0]   out_val_r [IN_FEATS];
  logic          out_last_r;

  logic          in_acc, emit_ok;
  logic          evict, wr, pend_load, pend_clr, out_load, out_last;
  src_t          out_src;
  logic [SW-1:0] head_sel, tail;
  logic [CW-1:0] cnt_sel;
  logic [TW-1:0] tail_full;
  logic [AW-1:0] raddr, waddr;
  logic [31:0]   stamp_rd, age, ud32, uf32, in_feat [IN_FEATS];
  logic          expired, fifo_full, listener_ok;
  logic [31:0]   rd_x  [IN_FEATS];
  logic [63:0]   sum_x [IN_FEATS];

  assign in_feat[0] = in_bus.feature_0;
  assign in_feat[1] = in_bus.feature_1;
  assign in_feat[2] = in_bus.feature_2;
  assign in_feat[3] = in_bus.feature_3;

  assign in_bus.ready = (state_r == S_IDLE);
  assign in_acc       = in_bus.valid && in_bus.ready;
  assign emit_ok      = !out_v_r || out_bus.ready;
  assign listener_ok  = (32'(in_bus.listener) < LISTENERS);

  // Head, count and tail of the listener in work.
  assign head_sel  = heads_r[cur_l_r];
  assign cnt_sel   = counts_r[cur_l_r];
  assign tail_full = TW'(head_sel) + TW'(cnt_sel);
  assign tail      = (tail_full >= TW'(FIFO_DEPTH)) ? SW'(tail_full - TW'(FIFO_DEPTH))
                                                    : SW'(tail_full);
  assign raddr     = {cur_l_r, head_sel};
  assign waddr     = {cur_l_r, tail};

  // Effective depth and feature count from the registers.
  assign ud32 = (depth_r == 5'd0) ? 32'd1 :
                (32'(depth_r) > FIFO_DEPTH) ? 32'(FIFO_DEPTH) : 32'(depth_r);
  assign uf32 = (32'(feats_r) > FEATURES) ? 32'(FEATURES) : 32'(feats_r);
  assign fifo_full = (32'(cnt_sel) >= ud32);

  // Age check on the head record.
  assign age     = now_r - stamp_rd;
  assign expired = (age > window_r);

  tws_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_stamps (
    .clk   (clk),
    .we    (wr),
    .waddr (waddr),
    .wdata (now_r),
    .raddr (raddr),
    .rdata (stamp_rd)
  );

  // Feature lanes, padded out to the result width.
  for (genvar i = 0; i < IN_FEATS; i++) begin : g_pad
    if (i < FEATURES) begin : g_lane
      lane_ctl_t   ctl;
      logic        act;
      logic [31:0] rd;
      logic [63:0] sm;

      assign act = (32'(i) < uf32);
      assign ctl = '{we: wr, add: wr && act, sub: evict && act};

      tws_lane #(.LISTENERS(LISTENERS), .FIFO_DEPTH(FIFO_DEPTH)) u_lane (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .sel   (cur_l_r),
        .waddr (waddr),
        .raddr (raddr),
        .wdata (feat_r[i]),
        .rdata (rd),
        .sum   (sm)
      );

      assign rd_x[i]  = rd;
      assign sum_x[i] = sm;
    end else begin : g_zero
      assign rd_x[i]  = '0;
      assign sum_x[i] = '0;
    end
  end

  // Sequencer next-state and control.
  always_comb begin
    state_nxt = state_r;
    cur_l_nxt = cur_l_r;
    evict     = 1'b0;
    wr        = 1'b0;
    pend_load = 1'b0;
    pend_clr  = 1'b0;
    out_load  = 1'b0;
    out_src   = SRC_NONE;
    out_last  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cur_l_nxt = (action_t'(in_bus.action) == ACT_EXPIRE) ? '0 : LW'(in_bus.listener);
          case (action_t'(in_bus.action))
            ACT_PUSH:   state_nxt = listener_ok ? S_PUSH_RD : S_IDLE;
            ACT_EXPIRE: state_nxt = S_EXP_CHK;
            ACT_QUERY:  state_nxt = listener_ok ? S_EXP_CHK : S_IDLE;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_PUSH_RD: begin
        state_nxt = fifo_full ? S_PUSH_EV : S_PUSH_WR;
      end
      S_PUSH_EV: begin
        if (emit_ok) begin
          out_load  = 1'b1;
          out_src   = SRC_REC;
          out_last  = 1'b1;
          evict     = 1'b1;
          state_nxt = S_PUSH_WR;
        end
      end
      S_PUSH_WR: begin
        wr        = 1'b1;
        state_nxt = S_IDLE;
      end
      S_EXP_CHK, S_EXP_EV: begin
        if ((state_r == S_EXP_CHK) && (cnt_sel != '0)) begin
          state_nxt = S_EXP_EV;
        end else if ((state_r == S_EXP_EV) && expired) begin
          if (!pend_v_r || emit_ok) begin
            out_load  = pend_v_r;
            out_src   = SRC_PEND;
            pend_load = 1'b1;
            evict     = 1'b1;
            state_nxt = S_EXP_CHK;
          end
        end else if (action_t'(act_r) == ACT_QUERY) begin
          state_nxt = S_QRY;
        end else if (32'(cur_l_r) == LISTENERS - 1) begin
          state_nxt = S_FLUSH;
        end else begin
          cur_l_nxt = LW'(cur_l_r + 1'b1);
          state_nxt = S_EXP_CHK;
        end
      end
      S_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (emit_ok) begin
          out_load  = 1'b1;
          out_src   = SRC_PEND;
          out_last  = 1'b1;
          pend_clr  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_QRY: begin
        if (emit_ok) begin
          out_load = 1'b1;
          if (pend_v_r) begin
            out_src  = SRC_PEND;
            pend_clr = 1'b1;
          end else begin
            out_src   = SRC_SUM;
            out_last  = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state: sequencer, FIFO pointers, held-back record and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cur_l_r  <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      for (int i = 0; i < LISTENERS; i++) begin
        heads_r[i]  <= '0;
        counts_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      cur_l_r <= cur_l_nxt;
      if (evict) begin
        heads_r[cur_l_r]  <= (32'(head_sel) == FIFO_DEPTH - 1) ? '0 : SW'(head_sel + 1'b1);
        counts_r[cur_l_r] <= cnt_sel - 1'b1;
      end else if (wr) begin
        counts_r[cur_l_r] <= cnt_sel + 1'b1;
      end
      if (pend_load) begin
        pend_v_r <= 1'b1;
      end else if (pend_clr) begin
        pend_v_r <= 1'b0;
      end
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload registers: item, held-back record and output beat.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r <= in_bus.action;
      now_r <= in_bus.time_ms;
      for (int i = 0; i < IN_FEATS; i++) begin
        feat_r[i] <= in_feat[i];
      end
    end
    if (pend_load) begin
      pend_l_r     <= cur_l_r;
      pend_stamp_r <= stamp_rd;
      for (int i = 0; i < IN_FEATS; i++) begin
        pend_val_r[i] <= rd_x[i];
      end
    end
    if (out_load) begin
      out_last_r <= out_last;
      case (out_src)
        SRC_REC: begin
          out_kind_r  <= KIND_RECORD;
          out_l_r     <= 2'(cur_l_r);
          out_stamp_r <= stamp_rd;
          for (int i = 0; i < IN_FEATS; i++) begin
            out_val_r[i] <= 64'(rd_x[i]);
          end
        end
        SRC_PEND: begin
          out_kind_r  <= KIND_RECORD;
          out_l_r     <= 2'(pend_l_r);
          out_stamp_r <= pend_stamp_r;
          for (int i = 0; i < IN_FEATS; i++) begin
            out_val_r[i] <= 64'(pend_val_r[i]);
          end
        end
        default: begin
          out_kind_r  <= KIND_SUM;
          out_l_r     <= 2'(cur_l_r);
          out_stamp_r <= '0;
          for (int i = 0; i < IN_FEATS; i++) begin
            out_val_r[i] <= sum_x[i];
          end
        end
      endcase
    end
  end

  assign out_bus.valid        = out_v_r;
  assign out_bus.kind         = out_kind_r;
  assign out_bus.listener_out = out_l_r;
  assign out_bus.stamp_out    = out_stamp_r;
  assign out_bus.value_0      = out_val_r[0];
  assign out_bus.value_1      = out_val_r[1];
  assign out_bus.value_2      = out_val_r[2];
  assign out_bus.value_3      = out_val_r[3];
  assign out_bus.last         = out_last_r;

  // A held-back record never survives into the idle state.
  `TWS_ASSERT_NOW(a_pend_not_idle, pend_v_r, state_r != S_IDLE, "record held while idle")
  // Evictions only take records from a non-empty FIFO.
  `TWS_ASSERT_NOW(a_evict_nonempty, evict, cnt_sel != '0, "eviction from empty FIFO")
  // A sum reply always closes its item.
  `TWS_ASSERT_NOW(a_sum_last, out_v_r && (out_kind_r == KIND_SUM), out_last_r,
                  "sum reply without last")
  // An accepted expire always starts its walk in S_EXP_CHK.
  `TWS_ASSERT_NEXT(a_acc_busy, in_acc && (action_t'(in_bus.action) == ACT_EXPIRE),
                   state_r == S_EXP_CHK, "expire did not start")

endmodule
